// File: hdl/tsacn_pkg.sv
// Shared types, constants and a helper function of the triangle setup block.
package tsacn_pkg;

  localparam int unsigned VERTEX_DEPTH = 4096;
  localparam int unsigned COORD_WIDTH  = 32;
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned FIELD_W      = 32;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic [IDX_W-1:0]          index_a;
    logic [IDX_W-1:0]          index_b;
    logic [IDX_W-1:0]          index_c;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0]        area;
    logic signed [FIELD_W-1:0] center_x;
    logic signed [FIELD_W-1:0] center_y;
    logic signed [FIELD_W-1:0] center_z;
    logic [FIELD_W-1:0]        radius;
    logic signed [FIELD_W-1:0] normal_x;
    logic signed [FIELD_W-1:0] normal_y;
    logic signed [FIELD_W-1:0] normal_z;
    logic                      degenerate;
  } res_t;

  // three vertices, element 0 is x
  typedef struct packed {
    logic [2:0][FIELD_W-1:0] a;
    logic [2:0][FIELD_W-1:0] b;
    logic [2:0][FIELD_W-1:0] c;
  } tri_t;

  // Reduce a slot index modulo the store depth; the quotient stays below 256
  // for any depth of at least 16, so eight conditional subtracts suffice.
  function automatic logic [IDX_W-1:0] slot_mod(input logic [IDX_W-1:0] idx,
                                                input int unsigned depth);
    logic [31:0] v;
    v = 32'(idx);
    for (int k = 7; k >= 0; k--) begin
      if (v >= (depth << k)) begin
        v = v - (depth << k);
      end
    end
    return v[IDX_W-1:0];
  endfunction

endpackage

// File: hdl/tsacn_front.sv
// Front end: accept requests, keep the vertex store, fetch triangle vertices.
module tsacn_front #(
  parameter int unsigned VERTEX_DEPTH = tsacn_pkg::VERTEX_DEPTH,
  parameter int unsigned COORD_WIDTH  = tsacn_pkg::COORD_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  tsacn_pkg::req_t   req_i,
  output logic              vld_o,
  output tsacn_pkg::tri_t   tri_o
);

  localparam int unsigned CW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam int unsigned AW = $clog2(VERTEX_DEPTH);

  // one copy of the store per read port, all written together
  logic [3*CW-1:0] mem_a [VERTEX_DEPTH];
  logic [3*CW-1:0] mem_b [VERTEX_DEPTH];
  logic [3*CW-1:0] mem_c [VERTEX_DEPTH];

  logic [3*CW-1:0] rd_a_q, rd_b_q, rd_c_q;
  logic            vld_q;
  logic [AW-1:0]   wr_addr, addr_a, addr_b, addr_c;
  logic [3*CW-1:0] wr_data;
  logic            wr_en, rd_en;

  function automatic logic [31:0] sext(input logic [CW-1:0] v);
    logic signed [CW-1:0] s;
    s = $signed(v);
    return 32'(s);
  endfunction

  assign wr_en   = accept_i && (req_i.kind == tsacn_pkg::KIND_VERTEX);
  assign rd_en   = accept_i && (req_i.kind == tsacn_pkg::KIND_TRIANGLE);
  assign wr_addr = AW'(tsacn_pkg::slot_mod(req_i.vertex_index, VERTEX_DEPTH));
  assign addr_a  = AW'(tsacn_pkg::slot_mod(req_i.index_a, VERTEX_DEPTH));
  assign addr_b  = AW'(tsacn_pkg::slot_mod(req_i.index_b, VERTEX_DEPTH));
  assign addr_c  = AW'(tsacn_pkg::slot_mod(req_i.index_c, VERTEX_DEPTH));
  assign wr_data = {req_i.pos_z[CW-1:0], req_i.pos_y[CW-1:0], req_i.pos_x[CW-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
      mem_c[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem_a[addr_a];
      rd_b_q <= mem_b[addr_b];
      rd_c_q <= mem_c[addr_c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= rd_en;
    end
  end

  assign vld_o = vld_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tri_o.a[i] = sext(rd_a_q[i*CW +: CW]);
      tri_o.b[i] = sext(rd_b_q[i*CW +: CW]);
      tri_o.c[i] = sext(rd_c_q[i*CW +: CW]);
    end
  end

endmodule

// File: hdl/tsacn_fifo.sv
// Short queue between the front end and the arithmetic pipeline.
module tsacn_fifo #(
  parameter int unsigned DEPTH = tsacn_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tsacn_pkg::tri_t data_i,
  input  logic            pop_i,
  output tsacn_pkg::tri_t data_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  tsacn_pkg::tri_t store_q [DEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [CNTW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign do_pop  = pop_i && !empty_o;
  assign do_push = push_i && (!full_o || do_pop);
  assign data_o  = store_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

endmodule

// File: hdl/tsacn_back.sv
// Arithmetic pipeline: cross product, centroid, radius, square roots, normal.
module tsacn_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  tsacn_pkg::tri_t tri_i,
  output logic            done_o,
  output tsacn_pkg::res_t res_o
);

  localparam int unsigned MW   = 52;   // cross magnitude after truncation
  localparam int unsigned QW   = 106;  // radicand width
  localparam int unsigned RTW  = 53;   // root width
  localparam int unsigned REMW = 57;
  localparam int unsigned NSTG = QW / 2;
  localparam int unsigned DSTG = 31;   // quotient bits of the normal
  localparam logic [2:0]  DIV3 = 3'd3;

  typedef struct packed {
    logic [2:0][MW-1:0] cm;
    logic [2:0]         cn;
    logic [2:0][31:0]   ctr;
  } side_t;

  typedef struct packed {
    logic [31:0]      area;
    logic [31:0]      radius;
    logic             deg;
    logic [2:0][31:0] ctr;
    logic [2:0]       cn;
  } dside_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [8:0] div3_chunk(input logic [1:0] rem_i,
                                            input logic [6:0] bits_i);
    logic [2:0] r;
    logic [6:0] q;
    r = {1'b0, rem_i};
    q = '0;
    for (int b = 6; b >= 0; b--) begin
      r = {r[1:0], bits_i[b]};
      if (r >= DIV3) begin
        r    = r - DIV3;
        q[b] = 1'b1;
      end
    end
    return {r[1:0], q};
  endfunction

  // ---------------- B1: differences and coordinate sum
  logic              v_q [1:12];
  logic [2:0][31:0]  va_q [1:8];
  logic signed [32:0] b1_d_q [3];
  logic signed [32:0] b1_e_q [3];
  logic signed [33:0] b1_s_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      b1_d_q[i] <= 33'($signed(tri_i.a[i])) - 33'($signed(tri_i.b[i]));
      b1_e_q[i] <= 33'($signed(tri_i.a[i])) - 33'($signed(tri_i.c[i]));
      b1_s_q[i] <= 34'($signed(tri_i.a[i])) + 34'($signed(tri_i.b[i]))
                 + 34'($signed(tri_i.c[i]));
    end
    va_q[1] <= tri_i.a;
    for (int k = 2; k <= 8; k++) begin
      va_q[k] <= va_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= 12; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      v_q[1] <= vld_i;
      for (int k = 2; k <= 12; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------- B2: partial products of the six cross terms
  logic signed [32:0] opx [6];
  logic signed [32:0] opy [6];
  logic [32:0]        mx [6];
  logic [32:0]        my [6];
  logic [31:0] b2_hh_q [6];
  logic [32:0] b2_hl_q [6];
  logic [32:0] b2_lh_q [6];
  logic [33:0] b2_ll_q [6];
  logic        b2_neg_q [6];

  always_comb begin
    opx[0] = b1_d_q[1]; opy[0] = b1_e_q[2];
    opx[1] = b1_d_q[2]; opy[1] = b1_e_q[1];
    opx[2] = b1_d_q[2]; opy[2] = b1_e_q[0];
    opx[3] = b1_d_q[0]; opy[3] = b1_e_q[2];
    opx[4] = b1_d_q[0]; opy[4] = b1_e_q[1];
    opx[5] = b1_d_q[1]; opy[5] = b1_e_q[0];
    for (int p = 0; p < 6; p++) begin
      mx[p] = mag33(opx[p]);
      my[p] = mag33(opy[p]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 6; p++) begin
      b2_hh_q[p]  <= 32'(mx[p][32:17]) * 32'(my[p][32:17]);
      b2_hl_q[p]  <= 33'(mx[p][32:17]) * 33'(my[p][16:0]);
      b2_lh_q[p]  <= 33'(mx[p][16:0]) * 33'(my[p][32:17]);
      b2_ll_q[p]  <= 34'(mx[p][16:0]) * 34'(my[p][16:0]);
      b2_neg_q[p] <= opx[p][32] ^ opy[p][32];
    end
  end

  // ---------------- B3: signed products
  logic signed [66:0] b3_p_q [6];
  logic [65:0]        prod [6];

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      prod[p] = {b2_hh_q[p], 34'b0} + 66'({b2_hl_q[p], 17'b0})
              + 66'({b2_lh_q[p], 17'b0}) + 66'(b2_ll_q[p]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < 6; p++) begin
      b3_p_q[p] <= b2_neg_q[p] ? -$signed({1'b0, prod[p]}) : $signed({1'b0, prod[p]});
    end
  end

  // ---------------- B4: cross components
  logic signed [67:0] b4_w_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      b4_w_q[i] <= 68'(b3_p_q[2*i]) - 68'(b3_p_q[2*i+1]);
    end
  end

  // ---------------- B5: truncated magnitude and sign, carried to the roots
  logic [2:0][MW-1:0] cm_q [5:12];
  logic [2:0]         cn_q [5:12];
  logic [67:0]        wmag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wmag[i] = b4_w_q[i][67] ? 68'(-b4_w_q[i]) : 68'(b4_w_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      cm_q[5][i] <= wmag[i][67:16];
      cn_q[5][i] <= b4_w_q[i][67];
    end
    for (int k = 6; k <= 12; k++) begin
      cm_q[k] <= cm_q[k-1];
      cn_q[k] <= cn_q[k-1];
    end
  end

  // ---------------- B6..B8: sum of squares of the cross magnitude
  logic [51:0]  b6_hh_q [3];
  logic [51:0]  b6_hl_q [3];
  logic [51:0]  b6_ll_q [3];
  logic [103:0] b7_sq_q [3];
  logic [QW-1:0] s_q [8:12];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      b6_hh_q[i] <= 52'(cm_q[5][i][51:26]) * 52'(cm_q[5][i][51:26]);
      b6_hl_q[i] <= 52'(cm_q[5][i][51:26]) * 52'(cm_q[5][i][25:0]);
      b6_ll_q[i] <= 52'(cm_q[5][i][25:0]) * 52'(cm_q[5][i][25:0]);
      b7_sq_q[i] <= {b6_hh_q[i], 52'b0} + 104'({b6_hl_q[i], 27'b0})
                  + 104'(b6_ll_q[i]);
    end
    s_q[8] <= QW'(b7_sq_q[0]) + QW'(b7_sq_q[1]) + QW'(b7_sq_q[2]);
    for (int k = 9; k <= 12; k++) begin
      s_q[k] <= s_q[k-1];
    end
  end

  // ---------------- B2..B6: divide the coordinate sums by three, 7 bits a stage
  logic [2:0][34:0] d3_num_q [2:6];
  logic [2:0][34:0] d3_q_q   [2:6];
  logic [2:0][1:0]  d3_r_q   [2:6];
  logic [2:0]       d3_neg_q [2:6];
  logic [33:0]      smag [3];
  logic [8:0]       ch2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      smag[i] = b1_s_q[i][33] ? 34'(-b1_s_q[i]) : 34'(b1_s_q[i]);
      ch2[i]  = div3_chunk(2'b00, {1'b0, smag[i][33:28]});
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d3_num_q[2][i] <= {1'b0, smag[i]};
      d3_q_q[2][i]   <= 35'(ch2[i][6:0]);
      d3_r_q[2][i]   <= ch2[i][8:7];
      d3_neg_q[2][i] <= b1_s_q[i][33];
    end
  end

  for (genvar k = 3; k <= 6; k++) begin : g_div3
    logic [8:0] ch [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ch[i] = div3_chunk(d3_r_q[k-1][i], d3_num_q[k-1][i][34-7*(k-2) -: 7]);
      end
    end
    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        d3_num_q[k][i] <= d3_num_q[k-1][i];
        d3_q_q[k][i]   <= {d3_q_q[k-1][i][27:0], ch[i][6:0]};
        d3_r_q[k][i]   <= ch[i][8:7];
        d3_neg_q[k][i] <= d3_neg_q[k-1][i];
      end
    end
  end

  // ---------------- B7..B12: centroid and radius sum of squares
  logic [2:0][31:0]   ctr_q [7:12];
  logic signed [32:0] b8_rd_q [3];
  logic [32:0]        b9_rm_q [3];
  logic [31:0]        b10_hh_q [3];
  logic [32:0]        b10_hl_q [3];
  logic [33:0]        b10_ll_q [3];
  logic [65:0]        b11_sq_q [3];
  logic [67:0]        b12_r_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ctr_q[7][i] <= d3_neg_q[6][i] ? 32'(35'd0 - d3_q_q[6][i]) : 32'(d3_q_q[6][i]);
      b8_rd_q[i]  <= 33'($signed(va_q[7][i])) - 33'($signed(ctr_q[7][i]));
      b9_rm_q[i]  <= mag33(b8_rd_q[i]);
      b10_hh_q[i] <= 32'(b9_rm_q[i][32:17]) * 32'(b9_rm_q[i][32:17]);
      b10_hl_q[i] <= 33'(b9_rm_q[i][32:17]) * 33'(b9_rm_q[i][16:0]);
      b10_ll_q[i] <= 34'(b9_rm_q[i][16:0]) * 34'(b9_rm_q[i][16:0]);
      b11_sq_q[i] <= {b10_hh_q[i], 34'b0} + 66'({b10_hl_q[i], 18'b0})
                   + 66'(b10_ll_q[i]);
    end
    b12_r_q <= 68'(b11_sq_q[0]) + 68'(b11_sq_q[1]) + 68'(b11_sq_q[2]);
    for (int k = 8; k <= 12; k++) begin
      ctr_q[k] <= ctr_q[k-1];
    end
  end

  // ---------------- square roots: lane 0 cross length, lane 1 radius
  logic [REMW-1:0] sq_rem_q  [1:NSTG][2];
  logic [RTW-1:0]  sq_root_q [1:NSTG][2];
  logic [QW-1:0]   sq_rad_q  [1:NSTG][2];
  side_t           sq_side_q [1:NSTG];
  logic            sq_v_q    [1:NSTG];

  for (genvar k = 1; k <= NSTG; k++) begin : g_sqrt
    logic [REMW-1:0] rem_in [2];
    logic [RTW-1:0]  root_in [2];
    logic [QW-1:0]   rad_in [2];
    side_t           side_in;
    logic            v_in;
    logic [REMW-1:0] rn [2];
    logic [REMW-1:0] tr [2];

    if (k == 1) begin : g_first
      always_comb begin
        rem_in[0]   = '0;
        rem_in[1]   = '0;
        root_in[0]  = '0;
        root_in[1]  = '0;
        rad_in[0]   = s_q[12];
        rad_in[1]   = QW'(b12_r_q);
        side_in.cm  = cm_q[12];
        side_in.cn  = cn_q[12];
        side_in.ctr = ctr_q[12];
        v_in        = v_q[12];
      end
    end else begin : g_next
      always_comb begin
        rem_in  = sq_rem_q[k-1];
        root_in = sq_root_q[k-1];
        rad_in  = sq_rad_q[k-1];
        side_in = sq_side_q[k-1];
        v_in    = sq_v_q[k-1];
      end
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        rn[l] = {rem_in[l][REMW-3:0], rad_in[l][QW-2*k+1 -: 2]};
        tr[l] = REMW'({root_in[l], 2'b01});
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 2; l++) begin
        if (rn[l] >= tr[l]) begin
          sq_rem_q[k][l]  <= rn[l] - tr[l];
          sq_root_q[k][l] <= {root_in[l][RTW-2:0], 1'b1};
        end else begin
          sq_rem_q[k][l]  <= rn[l];
          sq_root_q[k][l] <= {root_in[l][RTW-2:0], 1'b0};
        end
        sq_rad_q[k][l] <= rad_in[l];
      end
      sq_side_q[k] <= side_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else begin
        sq_v_q[k] <= v_in;
      end
    end
  end

  // ---------------- P: area, radius saturation, divider setup
  logic [RTW-1:0]   len;
  logic [RTW-1:0]   rrt;
  logic [RTW-1:0]   p_len_q;
  logic [2:0][RTW-1:0] p_r_q;
  logic [2:0]       p_m0_q;
  dside_t           p_side_q;
  logic             p_v_q;

  assign len = sq_root_q[NSTG][0];
  assign rrt = sq_root_q[NSTG][1];

  always_ff @(posedge clk_i) begin
    p_len_q         <= len;
    p_side_q.area   <= (|len[RTW-1:33]) ? '1 : len[32:1];
    p_side_q.radius <= (|rrt[RTW-1:32]) ? '1 : rrt[31:0];
    p_side_q.deg    <= (len == '0);
    p_side_q.ctr    <= sq_side_q[NSTG].ctr;
    p_side_q.cn     <= sq_side_q[NSTG].cn;
    for (int i = 0; i < 3; i++) begin
      p_r_q[i]  <= RTW'(sq_side_q[NSTG].cm[i][MW-1:1]);
      p_m0_q[i] <= sq_side_q[NSTG].cm[i][0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else begin
      p_v_q <= sq_v_q[NSTG];
    end
  end

  // ---------------- normal division, one quotient bit a stage
  logic [2:0][RTW-1:0]  dv_r_q [1:DSTG];
  logic [2:0][DSTG-1:0] dv_q_q [1:DSTG];
  logic [RTW-1:0]       dv_len_q [1:DSTG];
  dside_t               dv_side_q [1:DSTG];
  logic                 dv_v_q [1:DSTG];

  for (genvar j = 1; j <= DSTG; j++) begin : g_div
    logic [2:0][RTW-1:0]  r_in;
    logic [2:0][DSTG-1:0] q_in;
    logic [2:0]           bit_in;
    logic [RTW-1:0]       len_in;
    dside_t               side_in;
    logic                 v_in;
    logic [RTW:0]         rn [3];

    if (j == 1) begin : g_first
      always_comb begin
        r_in    = p_r_q;
        q_in    = '0;
        bit_in  = p_m0_q;
        len_in  = p_len_q;
        side_in = p_side_q;
        v_in    = p_v_q;
      end
    end else begin : g_next
      always_comb begin
        r_in    = dv_r_q[j-1];
        q_in    = dv_q_q[j-1];
        bit_in  = '0;
        len_in  = dv_len_q[j-1];
        side_in = dv_side_q[j-1];
        v_in    = dv_v_q[j-1];
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rn[i] = {r_in[i], bit_in[i]};
      end
    end

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        if (rn[i] >= {1'b0, len_in}) begin
          dv_r_q[j][i] <= RTW'(rn[i] - {1'b0, len_in});
          dv_q_q[j][i] <= {q_in[i][DSTG-2:0], 1'b1};
        end else begin
          dv_r_q[j][i] <= rn[i][RTW-1:0];
          dv_q_q[j][i] <= {q_in[i][DSTG-2:0], 1'b0};
        end
      end
      dv_len_q[j]  <= len_in;
      dv_side_q[j] <= side_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j] <= 1'b0;
      end else begin
        dv_v_q[j] <= v_in;
      end
    end
  end

  // ---------------- result register
  tsacn_pkg::res_t res_q;
  logic            done_q;
  logic [2:0][31:0] nrm;
  dside_t          fin;

  assign fin = dv_side_q[DSTG];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fin.deg) begin
        nrm[i] = '0;
      end else if (fin.cn[i]) begin
        nrm[i] = 32'd0 - 32'(dv_q_q[DSTG][i]);
      end else begin
        nrm[i] = 32'(dv_q_q[DSTG][i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.area       <= fin.deg ? '0 : fin.area;
    res_q.center_x   <= fin.ctr[0];
    res_q.center_y   <= fin.ctr[1];
    res_q.center_z   <= fin.ctr[2];
    res_q.radius     <= fin.radius;
    res_q.normal_x   <= nrm[0];
    res_q.normal_y   <= nrm[1];
    res_q.normal_z   <= nrm[2];
    res_q.degenerate <= fin.deg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v_q[DSTG];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: hdl/triangle_setup_area_center_normal.sv
// Top level of the triangle setup block: area, centroid, radius, unit normal.
//
//  channel   signals               direction  meaning
//  request   start, req_i / busy   in / out   vertex write or triangle request
//  result    done_o, res_o         out        one result per triangle request
//
// A request is taken at a rising edge with start high and busy low. Requests
// may follow each other in every cycle: one triangle per clock sustained.
// A triangle's result shows on res_o, with done_o high, for exactly one cycle,
// after its request has passed the store read, 1 queue slot, 12 arithmetic
// stages, 53 square root stages, 1 setup stage, 31 division stages and
// 1 output register. Vertex requests give no result. The receiver cannot hold
// results off, so the pipeline never stalls; busy rises only if the queue
// fills. Reset clears control state only; the vertex store is undefined
// until written and needs no clearing pass.
module triangle_setup_area_center_normal #(
  parameter int unsigned VERTEX_DEPTH = tsacn_pkg::VERTEX_DEPTH,
  parameter int unsigned COORD_WIDTH  = tsacn_pkg::COORD_WIDTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  tsacn_pkg::req_t req_i,
  output logic            done_o,
  output tsacn_pkg::res_t res_o
);

  logic            accept;
  logic            fr_vld;
  tsacn_pkg::tri_t fr_tri;
  tsacn_pkg::tri_t q_tri;
  logic            q_empty;
  logic            q_full;

  // take a request whenever the queue has room
  assign accept = start && !busy;
  assign busy   = q_full;

  // front end: write vertices, fetch the three vertices of a triangle
  tsacn_front #(
    .VERTEX_DEPTH(VERTEX_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .req_i   (req_i),
    .vld_o   (fr_vld),
    .tri_o   (fr_tri)
  );

  // decouple the front end from the arithmetic; drain every cycle
  tsacn_fifo #(
    .DEPTH(tsacn_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_vld),
    .data_i (fr_tri),
    .pop_i  (!q_empty),
    .data_o (q_tri),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // back end: fixed-latency pipeline, one triangle per cycle
  tsacn_back u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (!q_empty),
    .tri_i (q_tri),
    .done_o(done_o),
    .res_o (res_o)
  );

endmodule

// File: hdl/tsacn_checker.sv
// Port-level checks of the triangle setup block and their binding.
module tsacn_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input tsacn_pkg::req_t req_i,
  input logic            done_o,
  input tsacn_pkg::res_t res_o
);

  // a degenerate triangle has zero area and zero normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.degenerate |-> res_o.area == '0 && res_o.normal_x == '0 &&
      res_o.normal_y == '0 && res_o.normal_z == '0)
    else $error("degenerate result with nonzero area or normal");

  // a proper triangle has a nonzero normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.degenerate |->
      (res_o.normal_x != '0 || res_o.normal_y != '0 || res_o.normal_z != '0))
    else $error("zero normal on a proper triangle");

  // normal components stay within one unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.normal_x <= 32'sd1073741824 && res_o.normal_x >= -32'sd1073741824 &&
      res_o.normal_y <= 32'sd1073741824 && res_o.normal_y >= -32'sd1073741824 &&
      res_o.normal_z <= 32'sd1073741824 && res_o.normal_z >= -32'sd1073741824)
    else $error("normal component beyond one unit");

  // no result right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !done_o)
    else $error("result strobe right after reset");

endmodule

bind triangle_setup_area_center_normal tsacn_checker u_tsacn_checker (.*);
